// ===== rtl/crrc_pkg.sv =====
// ----------------------------------------------------------------------------
// crrc_pkg
// Shared types and codes for the code region range classifier.
// ----------------------------------------------------------------------------
package crrc_pkg;

    localparam int unsigned ADDR_W = 64;

    typedef enum logic [1:0] {
        MODE_ADD_IMAGE   = 2'd0,
        MODE_ADD_SECTION = 2'd1,
        MODE_ADD_ROUTINE = 2'd2,
        MODE_LOOKUP      = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_IMAGE   = 2'd1,
        ST_NO_SECTION = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_stop;
        logic              whitelist_flag;
        logic [ADDR_W-1:0] query_address;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic       image_hit;
        logic [3:0] image_slot;
        logic       section_hit;
        logic [5:0] section_slot;
        logic       routine_hit;
        logic [7:0] routine_slot;
        logic       is_whitelisted;
    } t_out_word;

    // Scan level being walked by the datapath.
    typedef enum logic [1:0] {
        LVL_IMAGE   = 2'd0,
        LVL_SECTION = 2'd1,
        LVL_ROUTINE = 2'd2
    } t_level;

    // Controller to datapath.
    typedef struct packed {
        logic   load;       // capture input word
        logic   write_add;  // perform the add held in the word register
        logic   scan_start; // reset scan index for level
        logic   scan_step;  // issue read of current index, advance
        logic   publish;    // copy finished result into the output register
        t_level level;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_lookup;
        logic last_idx;     // last issued index is the final one of the level
        logic empty;        // level holds no entries
        logic hit;          // compare on the registered read of the last issued index matched
        logic hit_valid;    // compare result is fresh
    } t_stat;

endpackage

// ===== rtl/crrc_if.sv =====
// ----------------------------------------------------------------------------
// crrc_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface crrc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/crrc_datapath.sv =====
// ----------------------------------------------------------------------------
// crrc_datapath
// Region tables, scan index, range compare and result assembly.
// ----------------------------------------------------------------------------
module crrc_datapath #(
    parameter int MAX_IMAGES   = 16,
    parameter int MAX_SECTIONS = 64,
    parameter int MAX_ROUTINES = 256,
    parameter int ADDR_BITS    = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crrc_pkg::t_in_word i_word,
    input  crrc_pkg::t_cmd     i_cmd,
    output crrc_pkg::t_stat    o_stat,
    output crrc_pkg::t_out_word o_result
);
    import crrc_pkg::*;

    localparam int IW = (MAX_IMAGES   > 1) ? $clog2(MAX_IMAGES)   : 1;
    localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int RW = (MAX_ROUTINES > 1) ? $clog2(MAX_ROUTINES) : 1;
    localparam int IC = $clog2(MAX_IMAGES + 1);
    localparam int SC = $clog2(MAX_SECTIONS + 1);
    localparam int RC = $clog2(MAX_ROUTINES + 1);
    localparam int XW = (RW > SW) ? ((RW > IW) ? RW : IW) : ((SW > IW) ? SW : IW);

    // Memories: {lo, hi, flag/owner}
    logic [ADDR_BITS-1:0] img_lo [MAX_IMAGES];
    logic [ADDR_BITS-1:0] img_hi [MAX_IMAGES];
    logic                 img_wh [MAX_IMAGES];
    logic [ADDR_BITS-1:0] sec_lo [MAX_SECTIONS];
    logic [ADDR_BITS-1:0] sec_hi [MAX_SECTIONS];
    logic [IW-1:0]        sec_own [MAX_SECTIONS];
    logic [ADDR_BITS-1:0] rtn_lo [MAX_ROUTINES];
    logic [ADDR_BITS-1:0] rtn_hi [MAX_ROUTINES];
    logic                 rtn_wh [MAX_ROUTINES];
    logic [SW-1:0]        rtn_own [MAX_ROUTINES];

    t_in_word      r_word;
    t_out_word     r_res;
    logic [IC-1:0] r_img_tot;
    logic [SC-1:0] r_sec_tot;
    logic [RC-1:0] r_rtn_tot;
    logic [IW-1:0] r_open_img;
    logic          r_open_img_v;
    logic [SW-1:0] r_open_sec;
    logic          r_open_sec_v;

    // Scan state
    logic [XW-1:0] r_idx;
    logic [XW-1:0] r_rd_idx;
    logic          r_rd_v;
    t_level        r_rd_lvl;
    logic [ADDR_BITS-1:0] r_rd_lo, r_rd_hi;
    logic [SW-1:0] r_rd_own;
    logic          r_rd_wh;
    logic [IW-1:0] r_m_img;
    logic [SW-1:0] r_m_sec;
    logic          r_m_img_wh;

    logic [ADDR_BITS-1:0] w_lo, w_hi, w_a;
    assign w_lo = r_word.range_start[ADDR_BITS-1:0];
    assign w_hi = r_word.range_stop[ADDR_BITS-1:0];
    assign w_a  = r_word.query_address[ADDR_BITS-1:0];

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_add) begin
            unique case (t_mode'(r_word.mode))
                MODE_ADD_IMAGE: if (r_img_tot < IC'(MAX_IMAGES)) begin
                    img_lo[r_img_tot[IW-1:0]] <= w_lo;
                    img_hi[r_img_tot[IW-1:0]] <= w_hi;
                    img_wh[r_img_tot[IW-1:0]] <= r_word.whitelist_flag;
                end
                MODE_ADD_SECTION: if (r_open_img_v && r_sec_tot < SC'(MAX_SECTIONS)) begin
                    sec_lo[r_sec_tot[SW-1:0]]  <= w_lo;
                    sec_hi[r_sec_tot[SW-1:0]]  <= w_hi;
                    sec_own[r_sec_tot[SW-1:0]] <= r_open_img;
                end
                MODE_ADD_ROUTINE: if (r_open_sec_v && r_rtn_tot < RC'(MAX_ROUTINES)) begin
                    rtn_lo[r_rtn_tot[RW-1:0]]  <= w_lo;
                    rtn_hi[r_rtn_tot[RW-1:0]]  <= w_hi;
                    rtn_wh[r_rtn_tot[RW-1:0]]  <= r_word.whitelist_flag;
                    rtn_own[r_rtn_tot[RW-1:0]] <= r_open_sec;
                end
                default: ;
            endcase
        end
    end

    // Memory reads, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            unique case (i_cmd.level)
                LVL_IMAGE: begin
                    r_rd_lo  <= img_lo[r_idx[IW-1:0]];
                    r_rd_hi  <= img_hi[r_idx[IW-1:0]];
                    r_rd_wh  <= img_wh[r_idx[IW-1:0]];
                    r_rd_own <= '0;
                end
                LVL_SECTION: begin
                    r_rd_lo  <= sec_lo[r_idx[SW-1:0]];
                    r_rd_hi  <= sec_hi[r_idx[SW-1:0]];
                    r_rd_wh  <= 1'b0;
                    r_rd_own <= SW'(sec_own[r_idx[SW-1:0]]);
                end
                default: begin
                    r_rd_lo  <= rtn_lo[r_idx[RW-1:0]];
                    r_rd_hi  <= rtn_hi[r_idx[RW-1:0]];
                    r_rd_wh  <= rtn_wh[r_idx[RW-1:0]];
                    r_rd_own <= rtn_own[r_idx[RW-1:0]];
                end
            endcase
        end
    end

    logic w_hit;
    always_comb begin
        unique case (r_rd_lvl)
            LVL_IMAGE:   w_hit = (r_rd_lo <= w_a) && (r_rd_hi >= w_a);
            LVL_SECTION: w_hit = (r_rd_own == SW'(r_m_img)) && (r_rd_lo <= w_a)
                                 && (r_rd_hi >= w_a);
            default:     w_hit = (r_rd_own == r_m_sec) && (r_rd_lo <= w_a)
                                 && (r_rd_hi > w_a);
        endcase
    end

    logic [XW-1:0] w_last;
    always_comb begin
        unique case (i_cmd.level)
            LVL_IMAGE:   w_last = XW'(r_img_tot) - XW'(1);
            LVL_SECTION: w_last = XW'(r_sec_tot) - XW'(1);
            default:     w_last = XW'(r_rtn_tot) - XW'(1);
        endcase
    end

    always_comb begin
        o_stat.is_lookup = (t_mode'(r_word.mode) == MODE_LOOKUP);
        o_stat.last_idx  = (r_rd_idx == w_last);
        unique case (i_cmd.level)
            LVL_IMAGE:   o_stat.empty = (r_img_tot == '0);
            LVL_SECTION: o_stat.empty = (r_sec_tot == '0);
            default:     o_stat.empty = (r_rtn_tot == '0);
        endcase
        o_stat.hit       = w_hit;
        o_stat.hit_valid = r_rd_v;
    end

    // Output register, loaded once the result is complete
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            o_result <= r_res;
        end
    end

    // Control registers, scan index and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_tot    <= '0;
            r_sec_tot    <= '0;
            r_rtn_tot    <= '0;
            r_open_img   <= '0;
            r_open_img_v <= 1'b0;
            r_open_sec   <= '0;
            r_open_sec_v <= 1'b0;
            r_idx        <= '0;
            r_rd_v       <= 1'b0;
            r_rd_lvl     <= LVL_IMAGE;
        end else begin
            r_rd_v <= i_cmd.scan_step;
            if (i_cmd.scan_step) begin
                r_rd_idx <= r_idx;
                r_rd_lvl <= i_cmd.level;
                r_idx    <= r_idx + XW'(1);
            end
            if (i_cmd.scan_start) begin
                r_idx <= '0;
            end
            if (i_cmd.load) begin
                r_word <= i_word;
                r_res  <= '0;
                r_idx  <= '0;
            end
            // Record matches as the scan proceeds.
            if (r_rd_v && w_hit) begin
                unique case (r_rd_lvl)
                    LVL_IMAGE: begin
                        r_m_img              <= r_rd_idx[IW-1:0];
                        r_m_img_wh           <= r_rd_wh;
                        r_res.image_hit      <= 1'b1;
                        r_res.image_slot     <= 4'(r_rd_idx);
                        r_res.is_whitelisted <= r_rd_wh;
                    end
                    LVL_SECTION: begin
                        r_m_sec            <= r_rd_idx[SW-1:0];
                        r_res.section_hit  <= 1'b1;
                        r_res.section_slot <= 6'(r_rd_idx);
                    end
                    default: begin
                        r_res.routine_hit    <= 1'b1;
                        r_res.routine_slot   <= 8'(r_rd_idx);
                        r_res.is_whitelisted <= r_m_img_wh | r_rd_wh;
                    end
                endcase
            end
            if (i_cmd.write_add) begin
                unique case (t_mode'(r_word.mode))
                    MODE_ADD_IMAGE: begin
                        if (r_img_tot >= IC'(MAX_IMAGES)) begin
                            r_res.status <= ST_FULL;
                        end else begin
                            r_res.image_slot <= 4'(r_img_tot);
                            r_open_img   <= r_img_tot[IW-1:0];
                            r_open_img_v <= 1'b1;
                            r_open_sec   <= '0;
                            r_open_sec_v <= 1'b0;
                            r_img_tot    <= r_img_tot + IC'(1);
                        end
                    end
                    MODE_ADD_SECTION: begin
                        if (!r_open_img_v) begin
                            r_res.status <= ST_NO_IMAGE;
                        end else if (r_sec_tot >= SC'(MAX_SECTIONS)) begin
                            r_res.status <= ST_FULL;
                        end else begin
                            r_res.image_slot   <= 4'(r_open_img);
                            r_res.section_slot <= 6'(r_sec_tot);
                            r_open_sec   <= r_sec_tot[SW-1:0];
                            r_open_sec_v <= 1'b1;
                            r_sec_tot    <= r_sec_tot + SC'(1);
                        end
                    end
                    MODE_ADD_ROUTINE: begin
                        if (!r_open_sec_v) begin
                            r_res.status <= ST_NO_SECTION;
                        end else if (r_rtn_tot >= RC'(MAX_ROUTINES)) begin
                            r_res.status <= ST_FULL;
                        end else begin
                            r_res.image_slot   <= 4'(r_open_img);
                            r_res.section_slot <= 6'(r_open_sec);
                            r_res.routine_slot <= 8'(r_rtn_tot);
                            r_rtn_tot    <= r_rtn_tot + RC'(1);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n && r_rd_v && (r_rd_lvl == LVL_SECTION) && w_hit) begin
            assert (r_res.image_hit)
            else $error("section match without image match");
        end
    end

    a_tot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rtn_tot <= RC'(MAX_ROUTINES))
        else $error("routine count overflow");
    a_sec_needs_img: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_sec_v |-> r_open_img_v)
        else $error("open section without open image");
    a_sec_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_sec_v |-> (r_open_sec < r_sec_tot[SW-1:0] || r_sec_tot == SC'(MAX_SECTIONS)))
        else $error("open section beyond count");

endmodule

// ===== rtl/crrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// crrc_ctrl
// Sequencer: handshakes, add commit and three-level scan.
// ----------------------------------------------------------------------------
module crrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  crrc_pkg::t_stat i_stat,
    output crrc_pkg::t_cmd  o_cmd
);
    import crrc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_ISSUE, S_WAIT, S_DONE
    } t_state;

    t_state r_state;
    t_level r_level;
    logic   r_out_valid;
    logic   w_publish;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    // Result moves to the output register once the previous one has gone.
    assign w_publish   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd            = '0;
        o_cmd.level      = r_level;
        o_cmd.load       = i_in_valid && o_in_ready;
        o_cmd.write_add  = (r_state == S_DECODE) && !i_stat.is_lookup;
        o_cmd.scan_step  = (r_state == S_ISSUE) && !i_stat.empty;
        o_cmd.scan_start = (r_state == S_WAIT) && i_stat.hit && (r_level != LVL_ROUTINE);
        o_cmd.publish    = w_publish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= LVL_IMAGE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_publish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (o_cmd.load) begin
                    r_state <= S_DECODE;
                    r_level <= LVL_IMAGE;
                end
                S_DECODE: r_state <= i_stat.is_lookup ? S_ISSUE : S_DONE;
                // One read per pass; wait for its compare.
                S_ISSUE: r_state <= i_stat.empty ? S_DONE : S_WAIT;
                S_WAIT: begin
                    if (i_stat.hit) begin
                        if (r_level == LVL_ROUTINE) begin
                            r_state <= S_DONE;
                        end else begin
                            r_level <= (r_level == LVL_IMAGE) ? LVL_SECTION : LVL_ROUTINE;
                            r_state <= S_ISSUE;
                        end
                    end else if (i_stat.last_idx) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_ISSUE;
                    end
                end
                S_DONE: if (w_publish) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result dropped before taken");
    a_wait_has_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> i_stat.hit_valid)
        else $error("compare without read");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_publish |=> r_out_valid)
        else $error("result not raised");

endmodule

// ===== rtl/code_region_range_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// code_region_range_classifier_unit
// Three-level region map (image, section, routine) with add and lookup.
// Adds: the word is decoded and committed, then its result is published;
// the next word is taken once the sequencer is back in idle. A lookup
// walks images, then sections, then routines, each compare a registered
// table read, then a range compare; one word at a time.
// An output register lets the next word start while a result waits.
// Reset (synchronous, active low) empties all tables; no clearing pass.
// ----------------------------------------------------------------------------
module code_region_range_classifier_unit #(
    parameter int MAX_IMAGES   = 16,
    parameter int MAX_SECTIONS = 64,
    parameter int MAX_ROUTINES = 256,
    parameter int ADDR_BITS    = 64
) (
    input logic i_clk,
    input logic i_rst_n,
    crrc_if.sink   s_in,
    crrc_if.source m_out
);
    import crrc_pkg::*;

    t_cmd  w_cmd;   // sequencer commands
    t_stat w_stat;  // datapath status

    // Datapath: tables, counters, scan index, result and output registers
    crrc_datapath #(
        .MAX_IMAGES  (MAX_IMAGES),
        .MAX_SECTIONS(MAX_SECTIONS),
        .MAX_ROUTINES(MAX_ROUTINES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (s_in.data),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_result(m_out.data)
    );

    // Sequencer: one word in flight, scan stops at first match per level
    crrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_in.valid),
        .o_in_ready (s_in.ready),
        .o_out_valid(m_out.valid),
        .i_out_ready(m_out.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

endmodule

// ===== tb/sv/code_region_range_classifier_unit_tb.sv =====
// ----------------------------------------------------------------------------
// code_region_range_classifier_unit_tb
// Drives add and lookup words into the region classifier and checks every
// result word against an in-bench model of the image/section/routine map.
// A short table of directed words comes first, then random map builds with
// lookups aimed at stored regions, under random idling on both channels.
// ----------------------------------------------------------------------------
module code_region_range_classifier_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crrc_pkg::*;

    localparam int N_IMG = 16;
    localparam int N_SEC = 64;
    localparam int N_RTN = 256;
    localparam int LIMIT = 3_000_000;
    localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;

    logic i_clk;
    logic i_rst_n;

    crrc_if #(.T(t_in_word))  in_ch ();
    crrc_if #(.T(t_out_word)) out_ch ();

    code_region_range_classifier_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch.sink),
        .m_out   (out_ch.source)
    );

    // In-bench copy of the region map
    logic [63:0] img_lo [N_IMG];
    logic [63:0] img_hi [N_IMG];
    logic        img_wl [N_IMG];
    int          img_cnt;
    logic [63:0] sec_lo [N_SEC];
    logic [63:0] sec_hi [N_SEC];
    int          sec_img [N_SEC];
    int          sec_cnt;
    logic [63:0] rtn_lo [N_RTN];
    logic [63:0] rtn_hi [N_RTN];
    logic        rtn_wl [N_RTN];
    int          rtn_sec [N_RTN];
    int          rtn_cnt;
    int          cur_img;
    logic        cur_img_ok;
    int          cur_sec;
    logic        cur_sec_ok;

    t_out_word pending_results [$];
    int        errors;
    int        cycles;
    int        snd_idle_pct;
    int        rcv_idle_pct;
    logic      hold_off;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic t_out_word mk_res(t_status st, logic ih, int is, logic sh,
                                         int ss, logic rh, int rs, logic wl);
        t_out_word r;
        r.status = st; r.image_hit = ih; r.image_slot = is[3:0];
        r.section_hit = sh; r.section_slot = ss[5:0];
        r.routine_hit = rh; r.routine_slot = rs[7:0]; r.is_whitelisted = wl;
        return r;
    endfunction

    // Computes the result word of one input word and updates the map.
    function automatic t_out_word classify_word(t_in_word w);
        int i, j, k;
        logic [63:0] a;
        a = w.query_address;
        case (t_mode'(w.mode))
            MODE_ADD_IMAGE: begin
                if (img_cnt >= N_IMG) return mk_res(ST_FULL, 0, 0, 0, 0, 0, 0, 0);
                img_lo[img_cnt] = w.range_start; img_hi[img_cnt] = w.range_stop;
                img_wl[img_cnt] = w.whitelist_flag;
                cur_img = img_cnt; cur_img_ok = 1; cur_sec = 0; cur_sec_ok = 0;
                img_cnt++;
                return mk_res(ST_OK, 0, cur_img, 0, 0, 0, 0, 0);
            end
            MODE_ADD_SECTION: begin
                if (!cur_img_ok) return mk_res(ST_NO_IMAGE, 0, 0, 0, 0, 0, 0, 0);
                if (sec_cnt >= N_SEC) return mk_res(ST_FULL, 0, 0, 0, 0, 0, 0, 0);
                sec_lo[sec_cnt] = w.range_start; sec_hi[sec_cnt] = w.range_stop;
                sec_img[sec_cnt] = cur_img;
                cur_sec = sec_cnt; cur_sec_ok = 1;
                sec_cnt++;
                return mk_res(ST_OK, 0, cur_img, 0, cur_sec, 0, 0, 0);
            end
            MODE_ADD_ROUTINE: begin
                if (!cur_sec_ok) return mk_res(ST_NO_SECTION, 0, 0, 0, 0, 0, 0, 0);
                if (rtn_cnt >= N_RTN) return mk_res(ST_FULL, 0, 0, 0, 0, 0, 0, 0);
                rtn_lo[rtn_cnt] = w.range_start; rtn_hi[rtn_cnt] = w.range_stop;
                rtn_wl[rtn_cnt] = w.whitelist_flag; rtn_sec[rtn_cnt] = cur_sec;
                rtn_cnt++;
                return mk_res(ST_OK, 0, cur_img, 0, cur_sec, 0, rtn_cnt - 1, 0);
            end
            default: begin
                for (i = 0; i < img_cnt; i++)
                    if (img_lo[i] <= a && img_hi[i] >= a) break;
                if (i >= img_cnt) return mk_res(ST_OK, 0, 0, 0, 0, 0, 0, 0);
                for (j = 0; j < sec_cnt; j++)
                    if (sec_img[j] == i && sec_lo[j] <= a && sec_hi[j] >= a) break;
                if (j >= sec_cnt) return mk_res(ST_OK, 1, i, 0, 0, 0, 0, img_wl[i]);
                // routine stop is exclusive
                for (k = 0; k < rtn_cnt; k++)
                    if (rtn_sec[k] == j && rtn_lo[k] <= a && rtn_hi[k] > a) break;
                if (k >= rtn_cnt) return mk_res(ST_OK, 1, i, 1, j, 0, 0, img_wl[i]);
                return mk_res(ST_OK, 1, i, 1, j, 1, k, img_wl[i] | rtn_wl[k]);
            end
        endcase
    endfunction

    function automatic t_in_word mk_word(t_mode m, logic [63:0] lo, logic [63:0] hi,
                                         logic wl, logic [63:0] a);
        t_in_word w;
        w.mode = m; w.range_start = lo; w.range_stop = hi;
        w.whitelist_flag = wl; w.query_address = a;
        return w;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // Sends one word; checks a typed-in expectation when given.
    // Valid stays high after acceptance until the next word or an idle cycle.
    task automatic send_word(input t_in_word w, input logic has_fixed,
                             input t_out_word fixed);
        t_out_word p;
        while ($urandom_range(99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        p = classify_word(w);
        if (has_fixed && p !== fixed) report("directed row vs model", p, fixed);
        pending_results.push_back(has_fixed ? fixed : p);
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Picks an address, mostly near a stored region, so lookups land on hits and edges.
    function automatic logic [63:0] aimed_addr();
        int s;
        logic [63:0] b;
        s = $urandom_range(5);
        case (s)
            0: return rnd64();
            1: if (img_cnt > 0) begin
                   b = img_lo[$urandom_range(img_cnt - 1)];
                   return b + $urandom_range(2) - 1;
               end
            2: if (img_cnt > 0) return img_hi[$urandom_range(img_cnt - 1)];
            3: if (sec_cnt > 0) return sec_lo[$urandom_range(sec_cnt - 1)]
                                       + $urandom_range(40);
            default: if (rtn_cnt > 0) begin
                   b = rtn_hi[$urandom_range(rtn_cnt - 1)];
                   return b - $urandom_range(1);
               end
        endcase
        return rnd64();
    endfunction

    // Nested ranges under a base so lookups descend all three levels.
    task automatic random_phase(input int n);
        logic [63:0] base, lo;
        int m;
        repeat (n) begin
            m = $urandom_range(99);
            base = {8'($urandom_range(3)), 8'h00, 16'h0, $urandom()};
            if ($urandom_range(9) == 0) base = rnd64();
            if (m < 10)
                send_word(mk_word(MODE_ADD_IMAGE, base, base + $urandom_range(4096),
                                  $urandom_range(3) == 0, rnd64()), 0, '0);
            else if (m < 22) begin
                lo = (img_cnt > 0) ? img_lo[cur_img] + $urandom_range(512) : base;
                send_word(mk_word(MODE_ADD_SECTION, lo, lo + $urandom_range(1024),
                                  $urandom_range(1), rnd64()), 0, '0);
            end else if (m < 45) begin
                lo = (sec_cnt > 0) ? sec_lo[cur_sec] + $urandom_range(256) : base;
                send_word(mk_word(MODE_ADD_ROUTINE, lo, lo + $urandom_range(128),
                                  $urandom_range(1), rnd64()), 0, '0);
            end else if (m < 48)
                send_word(mk_word(t_mode'($urandom_range(2)), rnd64(), rnd64(),
                                  $urandom_range(1), rnd64()), 0, '0);
            else
                send_word(mk_word(MODE_LOOKUP, rnd64(), rnd64(), $urandom_range(1),
                                  aimed_addr()), 0, '0);
        end
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !hold_off && ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_out_word w, e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            w = out_ch.data;
            if (pending_results.size() == 0)
                report("unexpected result word", w, 0);
            else begin
                e = pending_results.pop_front();
                if (w.status !== e.status) report("status", w.status, e.status);
                if (w.image_hit !== e.image_hit)
                    report("image_hit", w.image_hit, e.image_hit);
                if (w.image_slot !== e.image_slot)
                    report("image_slot", w.image_slot, e.image_slot);
                if (w.section_hit !== e.section_hit)
                    report("section_hit", w.section_hit, e.section_hit);
                if (w.section_slot !== e.section_slot)
                    report("section_slot", w.section_slot, e.section_slot);
                if (w.routine_hit !== e.routine_hit)
                    report("routine_hit", w.routine_hit, e.routine_hit);
                if (w.routine_slot !== e.routine_slot)
                    report("routine_slot", w.routine_slot, e.routine_slot);
                if (w.is_whitelisted !== e.is_whitelisted)
                    report("is_whitelisted", w.is_whitelisted, e.is_whitelisted);
            end
        end
    end

    // Directed table; a row with chk set carries its typed-in result
    typedef struct {
        t_in_word  w;
        logic      chk;
        t_out_word r;
    } t_row;

    t_row dir_rows [$];

    initial begin
        int n;
        errors = 0; cycles = 0; hold_off = 1'b0;
        snd_idle_pct = 15; rcv_idle_pct = 48;
        img_cnt = 0; sec_cnt = 0; rtn_cnt = 0;
        cur_img = 0; cur_img_ok = 0; cur_sec = 0; cur_sec_ok = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;

        // empty map: lookup misses, parents missing
        dir_rows.push_back('{mk_word(MODE_LOOKUP, 0, 0, 1, 0), 1,
                             mk_res(ST_OK, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_word(MODE_ADD_SECTION, 0, ALL1, 1, 0), 1,
                             mk_res(ST_NO_IMAGE, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_word(MODE_ADD_ROUTINE, 0, ALL1, 1, 0), 1,
                             mk_res(ST_NO_SECTION, 0, 0, 0, 0, 0, 0, 0)});
        // full-range image, not whitelisted
        dir_rows.push_back('{mk_word(MODE_ADD_IMAGE, 0, ALL1, 0, ALL1), 1,
                             mk_res(ST_OK, 0, 0, 0, 0, 0, 0, 0)});
        // image present but no section yet
        dir_rows.push_back('{mk_word(MODE_ADD_ROUTINE, 0, ALL1, 1, 0), 1,
                             mk_res(ST_NO_SECTION, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_word(MODE_LOOKUP, 0, 0, 0, ALL1), 1,
                             mk_res(ST_OK, 1, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_word(MODE_ADD_SECTION, 64'h1000, 64'h1FFF, 1, 0), 1,
                             mk_res(ST_OK, 0, 0, 0, 0, 0, 0, 0)});
        // reversed section never matches
        dir_rows.push_back('{mk_word(MODE_ADD_SECTION, ALL1, 0, 0, 0), 1,
                             mk_res(ST_OK, 0, 0, 0, 1, 0, 0, 0)});
        dir_rows.push_back('{mk_word(MODE_ADD_SECTION, 64'h100, 64'h2000, 0, 0), 1,
                             mk_res(ST_OK, 0, 0, 0, 2, 0, 0, 0)});
        dir_rows.push_back('{mk_word(MODE_ADD_ROUTINE, 64'h1100, 64'h1200, 1, 0), 1,
                             mk_res(ST_OK, 0, 0, 0, 2, 0, 0, 0)});
        dir_rows.push_back('{mk_word(MODE_ADD_ROUTINE, 0, ALL1, 0, 0), 0, '0});
        // exclusive routine stop, section boundaries
        dir_rows.push_back('{mk_word(MODE_LOOKUP, 0, 0, 0, 64'h1200), 0, '0});
        dir_rows.push_back('{mk_word(MODE_LOOKUP, 0, 0, 0, 64'h11FF), 0, '0});
        dir_rows.push_back('{mk_word(MODE_LOOKUP, 0, 0, 0, 64'h1FFF), 0, '0});
        dir_rows.push_back('{mk_word(MODE_LOOKUP, 0, 0, 0, 64'h100), 0, '0});
        dir_rows.push_back('{mk_word(MODE_LOOKUP, 0, 0, 0, 64'h2001), 0, '0});
        // whitelisted image shadowed by the first; then a routine add refused, the new image has no section
        dir_rows.push_back('{mk_word(MODE_ADD_IMAGE, 64'h5000, 64'h5000, 1, 0), 1,
                             mk_res(ST_OK, 0, 1, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_word(MODE_LOOKUP, ALL1, ALL1, 1, 64'h5000), 1,
                             mk_res(ST_OK, 1, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_word(MODE_ADD_ROUTINE, 0, 1, 0, 0), 1,
                             mk_res(ST_NO_SECTION, 0, 0, 0, 0, 0, 0, 0)});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) send_word(dir_rows[r].w, dir_rows[r].chk, dir_rows[r].r);

        random_phase(100);
        // fill image table past its end to hit the full status
        repeat (N_IMG + 1)
            send_word(mk_word(MODE_ADD_IMAGE, rnd64(), ALL1, $urandom_range(1), 0), 0, '0);
        snd_idle_pct = 48; rcv_idle_pct = 15;
        random_phase(100);
        // section and routine tables past full
        n = 0;
        while (sec_cnt < N_SEC && n < 200) begin
            send_word(mk_word(MODE_ADD_SECTION, rnd64(), ALL1, 0, 0), 0, '0);
            n++;
        end
        send_word(mk_word(MODE_ADD_SECTION, 0, ALL1, 0, 0), 0, '0);
        n = 0;
        while (rtn_cnt < N_RTN && n < 400) begin
            send_word(mk_word(MODE_ADD_ROUTINE, 0, rnd64(), $urandom_range(1), 0), 0, '0);
            n++;
        end
        send_word(mk_word(MODE_ADD_ROUTINE, 0, ALL1, 0, 0), 0, '0);
        snd_idle_pct = 0; rcv_idle_pct = 0;
        // long receiver hold-off while words keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(20);
        join
        random_phase(50);
        in_ch.valid <= 1'b0;

        drain();
        repeat (2 * (N_IMG + N_SEC + N_RTN) + 20) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/crrc_pkg.sv
rtl/crrc_if.sv
rtl/crrc_datapath.sv
rtl/crrc_ctrl.sv
rtl/code_region_range_classifier_unit.sv
tb/sv/code_region_range_classifier_unit_tb.sv
